/* design/msapg_pkg.sv */
// Shared types and constants of the multi-axis step pulse generator.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none

package msapg_pkg;

   // Field widths of the channels and of the register port.
   localparam int CMD_W       = 3;
   localparam int AXIS_W      = 2;
   localparam int SPEED_W     = 20;
   localparam int COUNT_W     = 24;
   localparam int INTERVAL_W  = 20;
   localparam int OUT_W       = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;

   // Number of axes that own a default speed register.
   localparam int NUM_SPEED_REGS = 4;

   localparam logic [SPEED_W-1:0]    SPEED_RESET  = 20'd1000;
   localparam logic [INTERVAL_W-1:0] ELAPSED_MAX  = 20'hFFFFF;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MOVE       = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STOP       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STOP_ALL   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_ENABLE     = 3'd5;
   localparam logic [CMD_W-1:0] CMD_ENABLE_ALL = 3'd6;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [AXIS_W-1:0]  axis;
      logic [SPEED_W-1:0] speed;
      logic [COUNT_W-1:0] step_count;
      logic               forward;
      logic               enable_value;
   } req_item_type;

   typedef struct packed {
      logic [OUT_W-1:0] step_pulses;
      logic [OUT_W-1:0] direction_lines;
      logic [OUT_W-1:0] enable_lines;
      logic [OUT_W-1:0] running_mask;
   } rsp_item_type;

   // Controller to datapath.
   typedef struct packed {
      logic apply_item;     // apply a command that needs no division, load the result
      logic start_cmd_div;  // capture a start command and launch its division
      logic start_cfg_div;  // launch the division for a pending register write
      logic finish_cmd;     // finish the start command, load the result
      logic finish_cfg;     // store the interval of the register write
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic pend_any;   // some axis waits for its interval to be recomputed
      logic needs_div;  // the offered item is a start command that takes effect
      logic div_done;   // the divider holds a finished quotient
   } dp_status_type;

endpackage

`default_nettype wire

/* design/msapg_if.sv */
// Valid/ready channel interfaces for command items and result items.
// Depends on msapg_pkg for the field widths.
`default_nettype none

interface msapg_req_if;
   logic                             valid;
   logic                             ready;
   logic [msapg_pkg::CMD_W-1:0]      command;
   logic [msapg_pkg::AXIS_W-1:0]     axis;
   logic [msapg_pkg::SPEED_W-1:0]    speed;
   logic [msapg_pkg::COUNT_W-1:0]    step_count;
   logic                             forward;
   logic                             enable_value;

   modport source (output valid, command, axis, speed, step_count, forward, enable_value,
                   input ready);
   modport sink   (input valid, command, axis, speed, step_count, forward, enable_value,
                   output ready);
endinterface

interface msapg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [msapg_pkg::OUT_W-1:0]  step_pulses;
   logic [msapg_pkg::OUT_W-1:0]  direction_lines;
   logic [msapg_pkg::OUT_W-1:0]  enable_lines;
   logic [msapg_pkg::OUT_W-1:0]  running_mask;

   modport source (output valid, step_pulses, direction_lines, enable_lines, running_mask,
                   input ready);
   modport sink   (input valid, step_pulses, direction_lines, enable_lines, running_mask,
                   output ready);
endinterface

`default_nettype wire

/* design/multi_axis_step_pulse_generator.sv */
// Top level of the multi-axis step pulse generator: joins controller and datapath.
// Depends on msapg_pkg, msapg_if, msapg_ctrl and msapg_dp.
//
//   Channel   Direction  Signals                                  Meaning
//   req_if    in         valid/ready, command .. enable_value     one command or tick
//   rsp_if    out        valid/ready, step_pulses .. running_mask one result per command
//   csr_*     in         write enable, index, 20-bit data         default speed registers
//
// A tick, move, stop or enable item is applied when it transfers; its result is registered and shows
// in the cycle after the transfer. A start item with a nonzero speed waits for the serial divider,
// which forms the interval one quotient bit per cycle.
// A nonzero speed register write reruns that divider, and the input stays closed until
// it finishes. Reset is synchronous and brings back the default intervals at once.
// A stalled result holds the input closed until it transfers; the input reopens in the
// cycle of that transfer.
`default_nettype none

module multi_axis_step_pulse_generator #(
   parameter int NUM_AXES         = 4,
   parameter int TICKS_PER_SECOND = 1000000
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   msapg_req_if.sink                                 req_if,
   msapg_rsp_if.source                               rsp_if,
   input  wire logic                                 csr_write_enable,
   input  wire logic [msapg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [msapg_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   msapg_pkg::req_item_type  req_item;
   msapg_pkg::rsp_item_type  rsp_item;
   msapg_pkg::dp_cmd_type    dp_cmd;
   msapg_pkg::dp_status_type dp_status;
   logic                     req_ready;
   logic                     rsp_valid;

   // Gather the request payload.
   always_comb begin
      req_item              = '0;
      req_item.command      = req_if.command;
      req_item.axis         = req_if.axis;
      req_item.speed        = req_if.speed;
      req_item.step_count   = req_if.step_count;
      req_item.forward      = req_if.forward;
      req_item.enable_value = req_if.enable_value;
   end

   msapg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (dp_status),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (dp_cmd)
   );

   msapg_dp #(
      .NUM_AXES         (NUM_AXES),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_item         (req_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .rsp_item         (rsp_item)
   );

   // Drive the channels.
   assign req_if.ready           = req_ready;
   assign rsp_if.valid           = rsp_valid;
   assign rsp_if.step_pulses     = rsp_item.step_pulses;
   assign rsp_if.direction_lines = rsp_item.direction_lines;
   assign rsp_if.enable_lines    = rsp_item.enable_lines;
   assign rsp_if.running_mask    = rsp_item.running_mask;

endmodule

`default_nettype wire

/* design/msapg_div.sv */
// Serial restoring divider: a constant dividend over a 20-bit divisor, one bit a cycle.
// Depends on msapg_pkg for the interval width.
`default_nettype none

module msapg_div #(
   parameter int DIVIDEND = 1000000
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [msapg_pkg::SPEED_W-1:0]       divisor,
   output logic                                     done,
   output logic [msapg_pkg::INTERVAL_W-1:0]         quotient
);

   localparam int ITER  = msapg_pkg::INTERVAL_W;
   localparam int CNT_W = $clog2(ITER);
   localparam int REM_W = msapg_pkg::SPEED_W;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ITER-1:0]       quo_ff, quo_in;
   logic [REM_W-1:0]      dvs_ff, dvs_in;
   logic [REM_W:0]        trial;
   logic                  fits;

   // One restoring step: shift the next dividend bit into the remainder and try a subtract.
   assign trial = {rem_ff, quo_ff[ITER-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = ITER'(DIVIDEND);
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? REM_W'(trial - {1'b0, dvs_ff}) : trial[REM_W-1:0];
         quo_in = {quo_ff[ITER-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ITER - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Working registers carry no reset.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* design/msapg_ctrl.sv */
// Controller of the step pulse generator: sequences item acceptance, divisions and results.
// Depends on msapg_pkg for the command and status structs.
`default_nettype none

module msapg_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     rsp_ready,
   input  wire msapg_pkg::dp_status_type status,
   output logic                          req_ready,
   output logic                          rsp_valid,
   output msapg_pkg::dp_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_CFG,
      ST_DIV_CMD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   // The result register is free when empty or when its transfer happens now.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !status.pend_any && out_free;
   assign accept    = req_valid && req_ready;

   // Commands to the datapath.
   always_comb begin
      cmd               = '0;
      cmd.apply_item    = accept && !status.needs_div;
      cmd.start_cmd_div = accept && status.needs_div;
      cmd.start_cfg_div = (state_ff == ST_IDLE) && status.pend_any;
      cmd.finish_cfg    = (state_ff == ST_DIV_CFG) && status.div_done;
      cmd.finish_cmd    = (state_ff == ST_DIV_CMD) && status.div_done;
   end

   // Next state and result valid.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (status.pend_any) begin
               state_in = ST_DIV_CFG;
            end else if (accept && status.needs_div) begin
               state_in = ST_DIV_CMD;
            end else if (accept) begin
               rsp_valid_in = 1'b1;
            end
         end
         ST_DIV_CFG: begin
            if (status.div_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_CMD: begin
            if (status.div_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // No item is taken while a division is under way.
   a_no_accept_in_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("item offered ready during a division");

   // A start item that needs a division leads to the command division state.
   a_start_goes_div: assert property (@(posedge clock) disable iff (reset)
      (accept && status.needs_div) |=> (state_ff == ST_DIV_CMD))
      else $error("start item did not launch its division");

   // The divider only finishes while the controller waits for it.
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff != ST_IDLE))
      else $error("divider finished with the controller idle");

endmodule

`default_nettype wire

/* design/msapg_dp.sv */
// Datapath of the step pulse generator: per-axis state, tick stepping, speed registers,
// the interval divider and the result register. Depends on msapg_pkg and msapg_div.
`default_nettype none

module msapg_dp #(
   parameter int NUM_AXES         = 4,
   parameter int TICKS_PER_SECOND = 1000000
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire msapg_pkg::req_item_type              req_item,
   input  wire logic                                 csr_write_enable,
   input  wire logic [msapg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [msapg_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  wire msapg_pkg::dp_cmd_type                cmd,
   output msapg_pkg::dp_status_type                  status,
   output msapg_pkg::rsp_item_type                   rsp_item
);

   localparam int IDX_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
   localparam int A_EXT  = (IDX_W > msapg_pkg::AXIS_W) ? IDX_W : msapg_pkg::AXIS_W;
   localparam int C_EXT  = (IDX_W > msapg_pkg::CSR_INDEX_W) ? IDX_W : msapg_pkg::CSR_INDEX_W;
   localparam int PAD_W  = (NUM_AXES > msapg_pkg::OUT_W) ? NUM_AXES : msapg_pkg::OUT_W;
   localparam int CFG_AXES = (NUM_AXES < msapg_pkg::NUM_SPEED_REGS) ?
                             NUM_AXES : msapg_pkg::NUM_SPEED_REGS;
   localparam logic [msapg_pkg::INTERVAL_W-1:0] INTERVAL_RESET =
      msapg_pkg::INTERVAL_W'(TICKS_PER_SECOND / 1000);

   // Per-axis state.
   logic [msapg_pkg::INTERVAL_W-1:0] interval_ff [NUM_AXES];
   logic [msapg_pkg::INTERVAL_W-1:0] interval_in [NUM_AXES];
   logic [msapg_pkg::INTERVAL_W-1:0] elapsed_ff  [NUM_AXES];
   logic [msapg_pkg::INTERVAL_W-1:0] elapsed_in  [NUM_AXES];
   logic [msapg_pkg::COUNT_W-1:0]    remain_ff   [NUM_AXES];
   logic [msapg_pkg::COUNT_W-1:0]    remain_in   [NUM_AXES];
   logic [msapg_pkg::SPEED_W-1:0]    speed_ff    [NUM_AXES];
   logic [msapg_pkg::SPEED_W-1:0]    speed_in    [NUM_AXES];
   logic [NUM_AXES-1:0] cont_ff, cont_in;
   logic [NUM_AXES-1:0] active_ff, active_in;
   logic [NUM_AXES-1:0] heading_ff, heading_in;
   logic [NUM_AXES-1:0] powered_ff, powered_in;
   logic [NUM_AXES-1:0] pend_ff, pend_in;

   // Tick results per axis.
   logic [msapg_pkg::INTERVAL_W-1:0] tick_elapsed [NUM_AXES];
   logic [msapg_pkg::COUNT_W-1:0]    tick_remain  [NUM_AXES];
   logic [NUM_AXES-1:0]              tick_hit;
   logic [NUM_AXES-1:0]              rem_nz;
   logic [NUM_AXES-1:0]              pulses_in;

   // Decoded addresses.
   logic [A_EXT-1:0] req_ext;
   logic [C_EXT-1:0] csr_ext;
   logic [IDX_W-1:0] req_idx, csr_idx, pick_idx;
   logic             req_ok, csr_ok;

   // Captured operands of the running division.
   logic [IDX_W-1:0] div_axis_ff, div_axis_in;
   logic [IDX_W-1:0] cmd_idx_ff, cmd_idx_in;
   logic             cmd_fwd_ff, cmd_fwd_in;

   logic [msapg_pkg::SPEED_W-1:0]    div_divisor;
   logic [msapg_pkg::INTERVAL_W-1:0] div_quotient;
   logic                             div_start;
   logic                             div_done;

   msapg_pkg::rsp_item_type rsp_ff, rsp_in;
   logic [PAD_W-1:0] pulse_pad, dir_pad, en_pad, run_pad;

   assign req_ext = A_EXT'(req_item.axis);
   assign csr_ext = C_EXT'(csr_index);
   assign req_idx = req_ext[IDX_W-1:0];
   assign csr_idx = csr_ext[IDX_W-1:0];
   assign req_ok  = int'(req_item.axis) < NUM_AXES;
   assign csr_ok  = csr_write_enable && (int'(csr_index) < CFG_AXES);

   // Lowest axis whose interval waits for recomputation.
   always_comb begin
      pick_idx = '0;
      for (int a = NUM_AXES - 1; a >= 0; a--) begin
         if (pend_ff[a]) begin
            pick_idx = IDX_W'(a);
         end
      end
   end

   // Status to the controller.
   always_comb begin
      status           = '0;
      status.pend_any  = |pend_ff;
      status.needs_div = (req_item.command == msapg_pkg::CMD_START) && req_ok &&
                         (req_item.speed != '0);
      status.div_done  = div_done;
   end

   // Divider shared by start commands and register writes.
   assign div_start   = cmd.start_cfg_div || cmd.start_cmd_div;
   assign div_divisor = cmd.start_cfg_div ? speed_ff[pick_idx] : req_item.speed;

   msapg_div #(
      .DIVIDEND (TICKS_PER_SECOND)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // What one tick does to each axis, computed for all axes side by side.
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         tick_elapsed[a] = (elapsed_ff[a] != msapg_pkg::ELAPSED_MAX) ?
                           elapsed_ff[a] + msapg_pkg::INTERVAL_W'(1) : elapsed_ff[a];
         tick_hit[a]     = active_ff[a] && (tick_elapsed[a] >= interval_ff[a]);
         tick_remain[a]  = (remain_ff[a] != '0) ?
                           remain_ff[a] - msapg_pkg::COUNT_W'(1) : remain_ff[a];
         rem_nz[a]       = remain_ff[a] != '0;
      end
   end

   // Next state of all axes.
   always_comb begin
      interval_in = interval_ff;
      elapsed_in  = elapsed_ff;
      remain_in   = remain_ff;
      speed_in    = speed_ff;
      cont_in     = cont_ff;
      active_in   = active_ff;
      heading_in  = heading_ff;
      powered_in  = powered_ff;
      pend_in     = pend_ff;
      pulses_in   = '0;
      div_axis_in = div_axis_ff;
      cmd_idx_in  = cmd_idx_ff;
      cmd_fwd_in  = cmd_fwd_ff;

      // A pending recomputation is taken by the divider.
      if (cmd.start_cfg_div) begin
         pend_in[pick_idx] = 1'b0;
         div_axis_in       = pick_idx;
      end
      if (cmd.start_cmd_div) begin
         cmd_idx_in = req_idx;
         cmd_fwd_in = req_item.forward;
      end

      // Register write; a zero speed leaves the interval alone.
      if (csr_ok && (csr_write_data != '0)) begin
         speed_in[csr_idx] = csr_write_data;
         pend_in[csr_idx]  = 1'b1;
      end

      if (cmd.apply_item) begin
         unique case (req_item.command)
            msapg_pkg::CMD_TICK: begin
               for (int a = 0; a < NUM_AXES; a++) begin
                  if (active_ff[a]) begin
                     if (tick_hit[a]) begin
                        pulses_in[a]  = 1'b1;
                        elapsed_in[a] = '0;
                        if (!cont_ff[a]) begin
                           remain_in[a] = tick_remain[a];
                           if (tick_remain[a] == '0) begin
                              active_in[a] = 1'b0;
                           end
                        end
                     end else begin
                        elapsed_in[a] = tick_elapsed[a];
                     end
                  end
               end
            end
            msapg_pkg::CMD_MOVE: begin
               if (req_ok && (req_item.step_count != '0)) begin
                  heading_in[req_idx] = req_item.forward;
                  cont_in[req_idx]    = 1'b0;
                  remain_in[req_idx]  = req_item.step_count;
                  active_in[req_idx]  = 1'b1;
                  elapsed_in[req_idx] = interval_ff[req_idx];
               end
            end
            msapg_pkg::CMD_STOP: begin
               if (req_ok) begin
                  remain_in[req_idx] = '0;
                  cont_in[req_idx]   = 1'b0;
                  active_in[req_idx] = 1'b0;
               end
            end
            msapg_pkg::CMD_STOP_ALL: begin
               for (int a = 0; a < NUM_AXES; a++) begin
                  remain_in[a] = '0;
               end
               cont_in   = '0;
               active_in = '0;
            end
            msapg_pkg::CMD_ENABLE: begin
               if (req_ok) begin
                  powered_in[req_idx] = req_item.enable_value;
               end
            end
            msapg_pkg::CMD_ENABLE_ALL: begin
               powered_in = {NUM_AXES{req_item.enable_value}};
            end
            default: begin
               // An ignored start and the unused code change nothing.
            end
         endcase
      end

      // A start command takes effect once its interval is known.
      if (cmd.finish_cmd) begin
         interval_in[cmd_idx_ff] = div_quotient;
         heading_in[cmd_idx_ff]  = cmd_fwd_ff;
         cont_in[cmd_idx_ff]     = 1'b1;
         remain_in[cmd_idx_ff]   = '0;
         active_in[cmd_idx_ff]   = 1'b1;
         elapsed_in[cmd_idx_ff]  = '0;
      end
      if (cmd.finish_cfg) begin
         interval_in[div_axis_ff] = div_quotient;
      end
   end

   // Result fields show the state after the command; axes past the field width drop out.
   assign pulse_pad = PAD_W'(pulses_in);
   assign dir_pad   = PAD_W'(heading_in);
   assign en_pad    = PAD_W'(powered_in);
   assign run_pad   = PAD_W'(active_in);

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.apply_item || cmd.finish_cmd) begin
         rsp_in.step_pulses     = pulse_pad[msapg_pkg::OUT_W-1:0];
         rsp_in.direction_lines = dir_pad[msapg_pkg::OUT_W-1:0];
         rsp_in.enable_lines    = en_pad[msapg_pkg::OUT_W-1:0];
         rsp_in.running_mask    = run_pad[msapg_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            interval_ff[a] <= INTERVAL_RESET;
            elapsed_ff[a]  <= '0;
            remain_ff[a]   <= '0;
            speed_ff[a]    <= msapg_pkg::SPEED_RESET;
         end
         cont_ff    <= '0;
         active_ff  <= '0;
         heading_ff <= '0;
         powered_ff <= '0;
         pend_ff    <= '0;
      end else begin
         interval_ff <= interval_in;
         elapsed_ff  <= elapsed_in;
         remain_ff   <= remain_in;
         speed_ff    <= speed_in;
         cont_ff     <= cont_in;
         active_ff   <= active_in;
         heading_ff  <= heading_in;
         powered_ff  <= powered_in;
         pend_ff     <= pend_in;
      end
   end

   // Captured operands and the result register carry no reset.
   always_ff @(posedge clock) begin
      div_axis_ff <= div_axis_in;
      cmd_idx_ff  <= cmd_idx_in;
      cmd_fwd_ff  <= cmd_fwd_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_item = rsp_ff;

   // A counted axis that runs always has steps left.
   a_counted_has_steps: assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~cont_ff & ~rem_nz) == '0)
      else $error("counted axis running with no steps left");

   // The controller issues at most one datapath command in a cycle.
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.apply_item, cmd.start_cmd_div, cmd.start_cfg_div,
                cmd.finish_cmd, cmd.finish_cfg}))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

/* test/multi_axis_step_pulse_generator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the four-axis step pulse generator: directed and random
// command streams, each result checked against an in-bench model of the axis state.
// Depends on msapg_pkg, msapg_if and the multi_axis_step_pulse_generator top level.

module multi_axis_step_pulse_generator_tb;

   localparam int AXES = 4;
   localparam int unsigned TICK_RATE = 1000000;
   localparam int RANDOM_PHASES = 5;
   localparam int ITEMS_PER_PHASE = 110;

   // Command code that the block leaves without effect.
   localparam logic [msapg_pkg::CMD_W-1:0] CMD_RESERVED = 3'd7;

   typedef logic [msapg_pkg::CSR_DATA_W-1:0] speed_set_type [AXES];
   typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_RHYTHM} sink_mode_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_write_enable;
   logic [msapg_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [msapg_pkg::CSR_DATA_W-1:0]  csr_write_data;

   msapg_req_if req_if();
   msapg_rsp_if rsp_if();

   multi_axis_step_pulse_generator #(
      .NUM_AXES(AXES),
      .TICKS_PER_SECOND(TICK_RATE)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Model of the axis state, updated in transfer order.
   logic [msapg_pkg::INTERVAL_W-1:0] axis_interval [AXES];
   logic [msapg_pkg::INTERVAL_W-1:0] axis_elapsed [AXES];
   logic [msapg_pkg::COUNT_W-1:0]    axis_remaining [AXES];
   logic                             axis_continuous [AXES];
   logic                             axis_active [AXES];
   logic                             axis_heading [AXES];
   logic                             axis_powered [AXES];

   msapg_pkg::rsp_item_type expected_outputs [$];
   int failures;
   int burst_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Tick count between steps for a given speed.
   function automatic logic [msapg_pkg::INTERVAL_W-1:0] interval_for_speed(
      input logic [msapg_pkg::SPEED_W-1:0] speed);
      int unsigned divisor;
      int unsigned quotient;
      divisor = speed;
      quotient = TICK_RATE / divisor;
      return quotient[msapg_pkg::INTERVAL_W-1:0];
   endfunction

   function automatic void halt_axis(input int a);
      axis_remaining[a] = '0;
      axis_continuous[a] = 1'b0;
      axis_active[a] = 1'b0;
   endfunction

   function automatic void reset_axis_model();
      for (int a = 0; a < AXES; a++) begin
         axis_interval[a] = interval_for_speed(msapg_pkg::SPEED_RESET);
         axis_elapsed[a] = '0;
         halt_axis(a);
         axis_heading[a] = 1'b0;
         axis_powered[a] = 1'b0;
      end
   endfunction

   // Applies one command to the axis model and returns the outputs it leaves.
   function automatic msapg_pkg::rsp_item_type apply_command(
      input msapg_pkg::req_item_type item);
      msapg_pkg::rsp_item_type outcome;
      logic [msapg_pkg::OUT_W-1:0] pulses;
      int a;
      pulses = '0;
      a = item.axis;
      case (item.command)
         msapg_pkg::CMD_TICK: begin
            for (int i = 0; i < AXES; i++) begin
               if (axis_active[i]) begin
                  if (axis_elapsed[i] != msapg_pkg::ELAPSED_MAX)
                     axis_elapsed[i]++;
                  if (axis_elapsed[i] >= axis_interval[i]) begin
                     pulses[i] = 1'b1;
                     axis_elapsed[i] = '0;
                     if (!axis_continuous[i]) begin
                        if (axis_remaining[i] != 0)
                           axis_remaining[i]--;
                        if (axis_remaining[i] == 0)
                           axis_active[i] = 1'b0;
                     end
                  end
               end
            end
         end
         msapg_pkg::CMD_START: begin
            if (item.speed != 0) begin
               axis_interval[a] = interval_for_speed(item.speed);
               axis_heading[a] = item.forward;
               axis_continuous[a] = 1'b1;
               axis_remaining[a] = '0;
               axis_active[a] = 1'b1;
               axis_elapsed[a] = '0;
            end
         end
         msapg_pkg::CMD_MOVE: begin
            if (item.step_count != 0) begin
               axis_heading[a] = item.forward;
               axis_continuous[a] = 1'b0;
               axis_remaining[a] = item.step_count;
               axis_active[a] = 1'b1;
               axis_elapsed[a] = axis_interval[a];
            end
         end
         msapg_pkg::CMD_STOP: begin
            halt_axis(a);
         end
         msapg_pkg::CMD_STOP_ALL: begin
            for (int i = 0; i < AXES; i++)
               halt_axis(i);
         end
         msapg_pkg::CMD_ENABLE: begin
            axis_powered[a] = item.enable_value;
         end
         msapg_pkg::CMD_ENABLE_ALL: begin
            for (int i = 0; i < AXES; i++)
               axis_powered[i] = item.enable_value;
         end
         default: begin
         end
      endcase
      outcome.step_pulses = pulses;
      for (int i = 0; i < AXES; i++) begin
         outcome.direction_lines[i] = axis_heading[i];
         outcome.enable_lines[i] = axis_powered[i];
         outcome.running_mask[i] = axis_active[i];
      end
      return outcome;
   endfunction

   function automatic msapg_pkg::req_item_type make_item(
      input logic [msapg_pkg::CMD_W-1:0] command,
      input int axis,
      input logic [msapg_pkg::SPEED_W-1:0] speed,
      input logic [msapg_pkg::COUNT_W-1:0] step_count,
      input logic forward,
      input logic enable_value);
      msapg_pkg::req_item_type item;
      item.command = command;
      item.axis = axis[msapg_pkg::AXIS_W-1:0];
      item.speed = speed;
      item.step_count = step_count;
      item.forward = forward;
      item.enable_value = enable_value;
      return item;
   endfunction

   // Sends one command in bursts with random gaps and books its expected outputs.
   task automatic send_command(input msapg_pkg::req_item_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.command <= item.command;
      req_if.axis <= item.axis;
      req_if.speed <= item.speed;
      req_if.step_count <= item.step_count;
      req_if.forward <= item.forward;
      req_if.enable_value <= item.enable_value;
      do
         @(posedge clock);
      while (req_if.ready !== 1'b1);
      expected_outputs.push_back(apply_command(item));
   endtask

   // Closes the input and waits until every booked result has transferred.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (expected_outputs.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the selected default speed registers in index order; block must be idle.
   task automatic write_speed_registers(input logic [AXES-1:0] write_mask,
                                        input speed_set_type speeds);
      for (int i = 0; i < AXES; i++) begin
         if (write_mask[i]) begin
            csr_write_enable <= 1'b1;
            csr_index <= i[msapg_pkg::CSR_INDEX_W-1:0];
            csr_write_data <= speeds[i];
            @(posedge clock);
            if (speeds[i] != 0)
               axis_interval[i] = interval_for_speed(speeds[i]);
         end
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [msapg_pkg::CSR_DATA_W-1:0] random_speed_setting();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 20'd1;
         2: return 20'hFFFFF;
         3: return 20'd1000000;
         default: return 20'($urandom_range(100000, 1000000));
      endcase
   endfunction

   // Mostly ticks, with short intervals and short moves so that axes step often.
   function automatic msapg_pkg::req_item_type random_command();
      msapg_pkg::req_item_type item;
      int pick;
      item.axis = 2'($urandom_range(0, 3));
      item.speed = 20'($urandom);
      item.step_count = 24'($urandom);
      item.forward = 1'($urandom_range(0, 1));
      item.enable_value = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         item.command = msapg_pkg::CMD_TICK;
      end else if (pick < 62) begin
         item.command = msapg_pkg::CMD_START;
         case ($urandom_range(0, 19))
            0: item.speed = '0;
            1: item.speed = 20'hFFFFF;
            2: begin
            end
            default: item.speed = 20'($urandom_range(100000, 1000000));
         endcase
      end else if (pick < 78) begin
         item.command = msapg_pkg::CMD_MOVE;
         case ($urandom_range(0, 19))
            0: item.step_count = '0;
            1: begin
            end
            default: item.step_count = 24'($urandom_range(1, 6));
         endcase
      end else if (pick < 84) begin
         item.command = msapg_pkg::CMD_STOP;
      end else if (pick < 87) begin
         item.command = msapg_pkg::CMD_STOP_ALL;
      end else if (pick < 93) begin
         item.command = msapg_pkg::CMD_ENABLE;
      end else if (pick < 97) begin
         item.command = msapg_pkg::CMD_ENABLE_ALL;
      end else begin
         item.command = CMD_RESERVED;
      end
      return item;
   endfunction

   function automatic void check_field(input string field,
                                       input logic [msapg_pkg::OUT_W-1:0] want,
                                       input logic [msapg_pkg::OUT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %b, actual %b", $time, field, want, got);
         failures++;
      end
   endfunction

   // Result checker: each result transfer is matched against the oldest expectation.
   always @(posedge clock) begin
      msapg_pkg::rsp_item_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_outputs.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %b %b %b %b", $time,
                     rsp_if.step_pulses, rsp_if.direction_lines, rsp_if.enable_lines,
                     rsp_if.running_mask);
            failures++;
         end else begin
            want = expected_outputs.pop_front();
            check_field("step_pulses", want.step_pulses, rsp_if.step_pulses);
            check_field("direction_lines", want.direction_lines, rsp_if.direction_lines);
            check_field("enable_lines", want.enable_lines, rsp_if.enable_lines);
            check_field("running_mask", want.running_mask, rsp_if.running_mask);
         end
      end
   end

   // Result sink: switches to a random stall pattern whenever its hold count runs out.
   initial begin
      int hold;
      sink_mode_type mode;
      rsp_if.ready = 1'b0;
      hold = 0;
      mode = SINK_OPEN;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            mode = sink_mode_type'($urandom_range(0, 3));
            hold = $urandom_range(8, 120);
         end
         hold--;
         case (mode)
            SINK_OPEN:   rsp_if.ready <= 1'b1;
            SINK_COIN:   rsp_if.ready <= ($urandom_range(0, 1) == 1);
            SINK_SPARSE: rsp_if.ready <= ($urandom_range(0, 7) == 0);
            default:     rsp_if.ready <= ((hold % 3) != 0);
         endcase
      end
   end

   // Enable lines, the unused command code and a tick with every axis idle.
   task automatic test_enable_lines();
      send_command(make_item(msapg_pkg::CMD_ENABLE, 3, '0, '0, 1'b0, 1'b1));
      send_command(make_item(msapg_pkg::CMD_ENABLE_ALL, 0, '0, '0, 1'b0, 1'b1));
      send_command(make_item(msapg_pkg::CMD_ENABLE, 1, 20'hFFFFF, 24'hFFFFFF, 1'b1, 1'b0));
      send_command(make_item(CMD_RESERVED, 3, 20'hFFFFF, 24'hFFFFFF, 1'b1, 1'b1));
      send_command(make_item(msapg_pkg::CMD_TICK, 0, '0, '0, 1'b0, 1'b0));
   endtask

   // Continuous runs: zero speed ignored, speeds at and above the tick rate, slowest speed.
   task automatic test_continuous_runs();
      send_command(make_item(msapg_pkg::CMD_START, 0, '0, '0, 1'b1, 1'b0));
      send_command(make_item(msapg_pkg::CMD_START, 0, 20'd1000000, '0, 1'b1, 1'b0));
      send_command(make_item(msapg_pkg::CMD_START, 1, 20'hFFFFF, '0, 1'b0, 1'b0));
      send_command(make_item(msapg_pkg::CMD_START, 2, 20'd500000, '0, 1'b1, 1'b0));
      send_command(make_item(msapg_pkg::CMD_START, 3, 20'd1, '0, 1'b1, 1'b0));
      repeat (3) send_command(make_item(msapg_pkg::CMD_TICK, 0, '0, '0, 1'b0, 1'b0));
      send_command(make_item(msapg_pkg::CMD_STOP, 1, '0, '0, 1'b0, 1'b0));
      send_command(make_item(msapg_pkg::CMD_STOP_ALL, 0, '0, '0, 1'b0, 1'b0));
   endtask

   // Counted moves: zero count ignored, a move finishing, move over a run, start over a move.
   task automatic test_counted_moves();
      send_command(make_item(msapg_pkg::CMD_MOVE, 0, '0, '0, 1'b1, 1'b0));
      send_command(make_item(msapg_pkg::CMD_MOVE, 2, '0, 24'd2, 1'b0, 1'b0));
      repeat (4) send_command(make_item(msapg_pkg::CMD_TICK, 0, '0, '0, 1'b0, 1'b0));
      send_command(make_item(msapg_pkg::CMD_START, 1, 20'd250000, '0, 1'b0, 1'b0));
      send_command(make_item(msapg_pkg::CMD_MOVE, 1, '0, 24'hFFFFFF, 1'b1, 1'b0));
      send_command(make_item(msapg_pkg::CMD_TICK, 0, '0, '0, 1'b0, 1'b0));
      send_command(make_item(msapg_pkg::CMD_START, 1, 20'd1000000, '0, 1'b1, 1'b0));
      send_command(make_item(msapg_pkg::CMD_TICK, 0, '0, '0, 1'b0, 1'b0));
      send_command(make_item(msapg_pkg::CMD_STOP_ALL, 0, '0, '0, 1'b0, 1'b0));
   endtask

   // Register extremes, including a zero write that must keep the old interval.
   task automatic test_speed_registers();
      drain_results();
      write_speed_registers(4'b1111, '{20'd1, 20'd1000000, 20'hFFFFF, 20'd0});
      for (int a = 1; a < AXES; a++)
         send_command(make_item(msapg_pkg::CMD_MOVE, a, '0, 24'd1, 1'b1, 1'b0));
      repeat (2) send_command(make_item(msapg_pkg::CMD_TICK, 0, '0, '0, 1'b0, 1'b0));
      send_command(make_item(msapg_pkg::CMD_STOP_ALL, 0, '0, '0, 1'b0, 1'b0));
   endtask

   // Random command streams under several register settings.
   task automatic test_random_traffic();
      speed_set_type speeds;
      logic [AXES-1:0] write_mask;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         for (int a = 0; a < AXES; a++)
            speeds[a] = random_speed_setting();
         write_mask = (phase == 0) ? 4'b1111 : 4'($urandom_range(1, 15));
         write_speed_registers(write_mask, speeds);
         repeat (ITEMS_PER_PHASE) send_command(random_command());
      end
   endtask

   initial begin
      failures = 0;
      burst_left = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.command = msapg_pkg::CMD_TICK;
      req_if.axis = '0;
      req_if.speed = '0;
      req_if.step_count = '0;
      req_if.forward = 1'b0;
      req_if.enable_value = 1'b0;
      reset_axis_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_enable_lines();
      test_continuous_runs();
      test_counted_moves();
      test_speed_registers();
      test_random_traffic();
      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* files.f */
design/msapg_pkg.sv
design/msapg_if.sv
design/msapg_div.sv
design/msapg_ctrl.sv
design/msapg_dp.sv
design/multi_axis_step_pulse_generator.sv
test/multi_axis_step_pulse_generator_tb.sv
